@@ hdl/lllf_pkg.sv @@
// Shared types, codes and lookup functions for the lens link frame controller.
`timescale 1ns / 1ps

package lllf_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  // Input command codes
  localparam logic [1:0] CMD_HOST = 2'd0;
  localparam logic [1:0] CMD_RX   = 2'd1;
  localparam logic [1:0] CMD_SYNC = 2'd2;

  // Host operation codes
  localparam logic [4:0] OP_ZOOM_IN     = 5'd0;
  localparam logic [4:0] OP_ZOOM_OUT    = 5'd1;
  localparam logic [4:0] OP_ZOOM_STOP   = 5'd2;
  localparam logic [4:0] OP_ZOOM_SET    = 5'd3;
  localparam logic [4:0] OP_FOCUS_IN    = 5'd4;
  localparam logic [4:0] OP_FOCUS_OUT   = 5'd5;
  localparam logic [4:0] OP_FOCUS_STOP  = 5'd6;
  localparam logic [4:0] OP_FOCUS_SET   = 5'd7;
  localparam logic [4:0] OP_IRIS_OPEN   = 5'd8;
  localparam logic [4:0] OP_IRIS_CLOSE  = 5'd9;
  localparam logic [4:0] OP_IRIS_STOP   = 5'd10;
  localparam logic [4:0] OP_IRIS_SET    = 5'd11;
  localparam logic [4:0] OP_IRF_IN      = 5'd12;
  localparam logic [4:0] OP_IRF_OUT     = 5'd13;
  localparam logic [4:0] OP_IRF_STOP    = 5'd14;
  localparam logic [4:0] OP_FILTER_SLOT = 5'd15;
  localparam logic [4:0] OP_AF_MODE     = 5'd16;
  localparam logic [4:0] OP_AI_MODE     = 5'd17;
  localparam logic [4:0] OP_COUNT       = 5'd18;

  // Link constants and response codes
  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] RSP_ZOOM   = 8'h85;
  localparam logic [7:0] RSP_FOCUS  = 8'h84;
  localparam logic [7:0] RSP_IRIS   = 8'h86;
  localparam logic [7:0] RSP_VER    = 8'h73;
  localparam logic [2:0] SYNC_IDLE  = 3'd4;
  localparam logic [2:0] RX_LAST    = 3'(FRAME_BYTES - 1);

  // One decoded input: frame contents plus the status snapshot after it
  typedef struct packed {
    logic        send;
    logic [7:0]  addr;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  chk;
    logic [15:0] zoom;
    logic [15:0] focus;
    logic [15:0] iris;
    logic [15:0] version;
    logic [2:0]  slot;
    logic [1:0]  fmode;
    logic [1:0]  imode;
    logic        syncing;
    logic        err;
  } job_t;

  // Command and default data bytes {c1, c2, d1, d2} per host operation
  function automatic logic [31:0] op_bytes(input logic [4:0] op);
    logic [31:0] r;
    r = 32'h0;
    case (op)
      OP_ZOOM_IN:     r = 32'h00200000;
      OP_ZOOM_OUT:    r = 32'h00400000;
      OP_ZOOM_SET:    r = 32'h00820000;
      OP_FOCUS_IN:    r = 32'h01000000;
      OP_FOCUS_OUT:   r = 32'h00800000;
      OP_FOCUS_SET:   r = 32'h00810000;
      OP_IRIS_OPEN:   r = 32'h02000000;
      OP_IRIS_CLOSE:  r = 32'h04000000;
      OP_IRIS_SET:    r = 32'h00830000;
      OP_IRF_IN:      r = 32'h00090001;
      OP_IRF_OUT:     r = 32'h000B0001;
      OP_FILTER_SLOT: r = 32'h000B0000;
      OP_AF_MODE:     r = 32'h002B0000;
      OP_AI_MODE:     r = 32'h002D0000;
      default:        r = 32'h0;
    endcase
    return r;
  endfunction

  // Query command byte per sync step
  function automatic logic [7:0] query_code(input logic [1:0] step);
    logic [7:0] r;
    case (step)
      2'd0:    r = RSP_ZOOM;
      2'd1:    r = RSP_FOCUS;
      2'd2:    r = RSP_IRIS;
      default: r = RSP_VER;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/lllf_front.sv @@
// Front end: takes input items, keeps lens state and builds one job per item.
`timescale 1ns / 1ps

module lllf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_data,
  input  logic             accept,
  input  logic [1:0]       command,
  input  logic [4:0]       operation,
  input  logic [15:0]      value,
  input  logic [7:0]       received_byte,
  output lllf_pkg::job_t   job
);
  import lllf_pkg::*;

  // Lens state
  logic [7:0]  lens_address;
  logic [7:0]  rx [FRAME_BYTES-2];
  logic [2:0]  rx_count, rx_count_next;
  logic [2:0]  sync_step, sync_step_next;
  logic [15:0] zoom, zoom_next;
  logic [15:0] focus, focus_next;
  logic [15:0] iris, iris_next;
  logic [15:0] version, version_next;
  logic [2:0]  slot, slot_next;
  logic [1:0]  fmode, fmode_next;
  logic [1:0]  imode, imode_next;
  logic        err, err_next;

  logic        send;
  logic [7:0]  c1, c2, d1, d2;
  logic [31:0] tbl;
  logic [7:0]  rx_sum;
  logic [15:0] rx_word;

  assign tbl     = op_bytes(operation);
  assign rx_sum  = rx[0] + rx[1] + rx[2] + rx[3] + rx[4];
  assign rx_word = {rx[3], rx[4]};

  // Decode one item into next state and frame bytes
  always_comb begin
    rx_count_next  = rx_count;
    sync_step_next = sync_step;
    zoom_next      = zoom;
    focus_next     = focus;
    iris_next      = iris;
    version_next   = version;
    slot_next      = slot;
    fmode_next     = fmode;
    imode_next     = imode;
    err_next       = err;
    send           = 1'b0;
    c1             = 8'h00;
    c2             = 8'h00;
    d1             = 8'h00;
    d2             = 8'h00;
    case (command)
      CMD_HOST: begin
        if (operation < OP_COUNT) begin
          send = 1'b1;
          {c1, c2, d1, d2} = tbl;
          case (operation)
            OP_ZOOM_SET: begin
              zoom_next = value;
              {d1, d2}  = value;
            end
            OP_FOCUS_SET: begin
              focus_next = value;
              {d1, d2}   = value;
            end
            OP_IRIS_SET: begin
              iris_next = value;
              {d1, d2}  = value;
            end
            OP_FILTER_SLOT: begin
              if (value inside {[16'd2:16'd6]}) begin
                slot_next = value[2:0];
                d2        = value[7:0];
              end else begin
                send = 1'b0;
              end
            end
            OP_AF_MODE: begin
              if (value inside {[16'd1:16'd3]}) begin
                fmode_next = value[1:0];
                d2         = value[7:0];
              end else begin
                send = 1'b0;
              end
            end
            OP_AI_MODE: begin
              if (value inside {[16'd1:16'd2]}) begin
                imode_next = value[1:0];
                d2         = value[7:0];
              end else begin
                send = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_RX: begin
        if (rx_count == 3'd0) begin
          // hunt for the sync byte
          if (received_byte == SYNC_BYTE) rx_count_next = 3'd1;
        end else if (rx_count < RX_LAST) begin
          rx_count_next = rx_count + 3'd1;
        end else begin
          // received byte is the checksum of a complete frame
          rx_count_next = 3'd0;
          if (rx[0] == lens_address) begin
            if (sync_step < SYNC_IDLE) begin
              sync_step_next = sync_step + 3'd1;
              if (sync_step_next < SYNC_IDLE) begin
                send = 1'b1;
                c2   = query_code(sync_step_next[1:0]);
              end
            end
            if (rx_sum != received_byte) begin
              err_next = 1'b1;
            end else begin
              err_next = 1'b0;
              case (rx[2])
                RSP_ZOOM:  zoom_next    = rx_word;
                RSP_FOCUS: focus_next   = rx_word;
                RSP_IRIS:  iris_next    = rx_word;
                RSP_VER:   version_next = rx_word;
                default: ;
              endcase
            end
          end
        end
      end
      CMD_SYNC: begin
        sync_step_next = 3'd0;
        send           = 1'b1;
        c2             = query_code(2'd0);
      end
      default: ;
    endcase
  end

  // Job handed to the queue
  always_comb begin
    job.send    = send;
    job.addr    = lens_address;
    job.c1      = c1;
    job.c2      = c2;
    job.d1      = d1;
    job.d2      = d2;
    job.chk     = lens_address + c1 + c2 + d1 + d2;
    job.zoom    = zoom_next;
    job.focus   = focus_next;
    job.iris    = iris_next;
    job.version = version_next;
    job.slot    = slot_next;
    job.fmode   = fmode_next;
    job.imode   = imode_next;
    job.syncing = sync_step_next < SYNC_IDLE;
    job.err     = err_next;
  end

  // Received frame bytes, address through data low
  always_ff @(posedge clk) begin
    if (accept && command == CMD_RX && rx_count != 3'd0 && rx_count < RX_LAST) begin
      rx[rx_count - 3'd1] <= received_byte;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lens_address <= 8'h01;
      rx_count     <= 3'd0;
      sync_step    <= SYNC_IDLE;
      zoom         <= 16'h0;
      focus        <= 16'h0;
      iris         <= 16'h0;
      version      <= 16'h0;
      slot         <= 3'd0;
      fmode        <= 2'd0;
      imode        <= 2'd0;
      err          <= 1'b0;
    end else begin
      if (cfg_valid) lens_address <= cfg_data;
      if (accept) begin
        rx_count  <= rx_count_next;
        sync_step <= sync_step_next;
        zoom      <= zoom_next;
        focus     <= focus_next;
        iris      <= iris_next;
        version   <= version_next;
        slot      <= slot_next;
        fmode     <= fmode_next;
        imode     <= imode_next;
        err       <= err_next;
      end
    end
  end

endmodule

@@ hdl/lllf_queue.sv @@
// Job queue between the front end and the frame sequencer.
`timescale 1ns / 1ps

module lllf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  lllf_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output lllf_pkg::job_t rd_job,
  output logic           avail
);
  import lllf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = count == CNT_W'(DEPTH);
  assign avail  = count != '0;
  assign rd_job = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) store[wr_ptr] <= wr_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (!wr_en && rd_en) count <= count - 1'b1;
    end
  end

endmodule

@@ hdl/lllf_back.sv @@
// Frame sequencer: plays out one job as one or seven result beats.
`timescale 1ns / 1ps

module lllf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_avail,
  input  lllf_pkg::job_t q_job,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic           frame_valid,
  output logic [7:0]     frame_byte,
  output logic           last,
  output logic [15:0]    zoom_position,
  output logic [15:0]    focus_position,
  output logic [15:0]    iris_position,
  output logic [15:0]    lens_version,
  output logic [2:0]     filter_slot,
  output logic [1:0]     focus_mode,
  output logic [1:0]     iris_mode,
  output logic           syncing,
  output logic           checksum_error
);
  import lllf_pkg::*;

  job_t             cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;

  assign empty = !cur_valid;
  assign last  = !cur.send || idx == IDX_W'(FRAME_BYTES - 1);
  assign q_pop = q_avail && (!cur_valid || (pop && last));

  // Byte select across the frame
  always_comb begin
    frame_byte = 8'h00;
    if (cur.send) begin
      case (idx)
        3'd0:    frame_byte = SYNC_BYTE;
        3'd1:    frame_byte = cur.addr;
        3'd2:    frame_byte = cur.c1;
        3'd3:    frame_byte = cur.c2;
        3'd4:    frame_byte = cur.d1;
        3'd5:    frame_byte = cur.d2;
        default: frame_byte = cur.chk;
      endcase
    end
  end

  assign frame_valid    = cur.send;
  assign zoom_position  = cur.zoom;
  assign focus_position = cur.focus;
  assign iris_position  = cur.iris;
  assign lens_version   = cur.version;
  assign filter_slot    = cur.slot;
  assign focus_mode     = cur.fmode;
  assign iris_mode      = cur.imode;
  assign syncing        = cur.syncing;
  assign checksum_error = cur.err;

  // Current job payload
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_job;
  end

  // Beat sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (pop && cur_valid) begin
      if (last) cur_valid <= 1'b0;
      else idx <= idx + 1'b1;
    end
  end

endmodule

@@ hdl/lens_link_frame_controller.sv @@
// Lens link frame controller top level: front end, job queue and frame sequencer.
// Each accepted item gives either one status beat or a seven-byte transmit frame
// (FF, address, two command bytes, two data bytes, checksum), one beat per cycle
// while pop is held. The front end takes one item per cycle while the QUEUE_DEPTH job
// queue has room; the sequencer takes the next item from the queue only when the
// last beat of the current one is popped, so the sustained rate is set by its output.
// The first beat of an item reaches the result ports once the item has been written
// into the queue and then loaded into the sequencer's current-job register.
// lens_address (reset 1) is written through the cfg channel, which is always ready.
`timescale 1ns / 1ps

module lens_link_frame_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [4:0]  operation,
  input  logic [15:0] value,
  input  logic [7:0]  received_byte,
  output logic        empty,
  input  logic        pop,
  output logic        frame_valid,
  output logic [7:0]  frame_byte,
  output logic        last,
  output logic [15:0] zoom_position,
  output logic [15:0] focus_position,
  output logic [15:0] iris_position,
  output logic [15:0] lens_version,
  output logic [2:0]  filter_slot,
  output logic [1:0]  focus_mode,
  output logic [1:0]  iris_mode,
  output logic        syncing,
  output logic        checksum_error
);
  import lllf_pkg::*;

  job_t front_job;
  job_t q_job;
  logic accept;
  logic q_avail;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  lllf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .command       (command),
    .operation     (operation),
    .value         (value),
    .received_byte (received_byte),
    .job           (front_job)
  );

  lllf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_job (front_job),
    .full   (full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .avail  (q_avail)
  );

  lllf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_avail        (q_avail),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .frame_valid    (frame_valid),
    .frame_byte     (frame_byte),
    .last           (last),
    .zoom_position  (zoom_position),
    .focus_position (focus_position),
    .iris_position  (iris_position),
    .lens_version   (lens_version),
    .filter_slot    (filter_slot),
    .focus_mode     (focus_mode),
    .iris_mode      (iris_mode),
    .syncing        (syncing),
    .checksum_error (checksum_error)
  );

  // A beat without a frame byte is always the only beat of its item
  a_nofr_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_valid) |-> last)
    else $error("status-only beat without last");

  // A frame continues after a non-final beat is taken
  a_frame_cont: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_valid && !last && pop) |=> (!empty && frame_valid))
    else $error("frame cut short");

  // Zoom position, syncing and checksum error stay the same on every beat of one frame
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_valid && !last && pop) |=>
      ($stable(zoom_position) && $stable(syncing) && $stable(checksum_error)))
    else $error("status changed inside a frame");

  // Nothing is offered right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

endmodule
